// ===== hdl/fqmq_pkg.sv =====
// Shared types and constants for the FIFO queue with minimum query.
package fqmq_pkg;

    // Number of entries the queue holds; the occupancy field is sized for it.
    localparam int DEPTH    = 16;
    localparam int VALUE_W  = 32;
    localparam int OCC_W    = 5;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int TDATA_W  = 40;
    localparam int PAD_W    = TDATA_W - VALUE_W - OCC_W;

    // Largest signed 32-bit value, the start point of the minimum scan.
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_LIST   = 3'd3,
        ACT_MIN    = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_LIST,
        S_MIN,
        S_MIN_OUT
    } state_t;

endpackage

// ===== hdl/fifo_queue_with_min_query.sv =====
// FIFO queue of signed 32-bit values with list and minimum walks.
//
//   Channel | Signals                         | Content
//   --------+---------------------------------+-------------------------------------
//   input   | s_tvalid s_tready s_tdata s_tuser | tdata: value_in; tuser: action
//   output  | m_tvalid m_tready m_tdata m_tuser m_tlast | tdata: value_out, occupancy;
//           |                                 | tuser: status; tlast: last
//
// Clear, insert, unused actions and actions on an empty queue load their beat
// when accepted. Remove waits in S_REMOVE for the registered read of the entry
// store. List passes through S_LIST, one stored entry per beat; minimum makes
// one compare per stored entry in S_MIN, then loads its beat in S_MIN_OUT.
// The entry store has a single registered read port.
// Reset clears the pointers and count; the store contents are not cleared.
// A stalled output holds the list walk in place, and no input is taken until the
// current action has handed its last beat to the output register.
module fifo_queue_with_min_query (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fqmq_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value_in
    input  logic [fqmq_pkg::ACTION_W-1:0] s_tuser,   // [2:0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fqmq_pkg::TDATA_W-1:0]  m_tdata,   // [31:0] value_out, [36:32] occupancy
    output logic [fqmq_pkg::STATUS_W-1:0] m_tuser,   // [1:0] status
    output logic                          m_tlast
);
    import fqmq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Pointer advance with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    state_t                    state_reg, state_next;
    logic [PTR_W-1:0]          head_reg, head_next;
    logic [PTR_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [PTR_W-1:0]          walk_reg, walk_next;
    logic [CNT_W-1:0]          remain_reg, remain_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;

    logic                      m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]        out_value_reg, out_value_next;
    status_t                   out_status_reg, out_status_next;
    logic                      out_last_reg, out_last_next;
    logic [OCC_W-1:0]          out_occ_reg, out_occ_next;

    logic [VALUE_W-1:0]        mem [DEPTH];
    logic [VALUE_W-1:0]        rd_data_reg;
    logic [PTR_W-1:0]          rd_addr;
    logic                      mem_we;

    logic                      accept;
    logic                      out_free;
    logic                      load;
    logic                      step;
    logic                      empty;
    logic                      full;
    logic signed [VALUE_W-1:0] rd_signed;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign rd_signed = signed'(rd_data_reg);

    // Entry store: one write port at the tail, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tail_reg] <= s_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control and pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            walk_reg    <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            walk_reg    <= walk_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload and scan minimum.
    always_ff @(posedge clk)
    begin
        min_reg        <= min_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_occ_reg    <= out_occ_next;
    end

    // Sequencer: next state, pointer updates and output beat loading.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        remain_next     = remain_reg;
        min_next        = min_reg;
        mem_we          = 1'b0;
        step            = 1'b0;
        load            = 1'b0;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_occ_next    = out_occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                walk_next = head_reg;
                if (accept)
                begin
                    out_value_next  = '0;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    out_occ_next    = OCC_W'(count_reg);
                    remain_next     = count_reg;
                    min_next        = VALUE_MAX;
                    case (action_t'(s_tuser)) inside
                        ACT_CLEAR:
                        begin
                            head_next    = '0;
                            tail_next    = '0;
                            count_next   = '0;
                            out_occ_next = '0;
                            load         = 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            load = 1'b1;
                            if (full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                tail_next    = ptr_inc(tail_reg);
                                count_next   = count_reg + 1'b1;
                                out_occ_next = OCC_W'(count_reg + 1'b1);
                            end
                        end
                        ACT_REMOVE, ACT_LIST, ACT_MIN:
                        begin
                            if (empty)
                            begin
                                out_status_next = STAT_EMPTY;
                                load            = 1'b1;
                            end
                            else if (action_t'(s_tuser) == ACT_REMOVE)
                            begin
                                state_next = S_REMOVE;
                            end
                            else if (action_t'(s_tuser) == ACT_LIST)
                            begin
                                state_next = S_LIST;
                            end
                            else
                            begin
                                state_next = S_MIN;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end

            // The head entry was read at the accept edge.
            S_REMOVE:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_value_next = rd_data_reg;
                    out_occ_next   = OCC_W'(count_reg - 1'b1);
                    head_next      = ptr_inc(head_reg);
                    count_next     = count_reg - 1'b1;
                    state_next     = S_IDLE;
                end
            end

            // One stored entry per beat, oldest first.
            S_LIST:
            begin
                if (out_free)
                begin
                    step           = 1'b1;
                    load           = 1'b1;
                    out_value_next = rd_data_reg;
                    out_last_next  = (remain_reg == CNT_W'(1));
                    walk_next      = ptr_inc(walk_reg);
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // One signed compare per stored entry.
            S_MIN:
            begin
                step        = 1'b1;
                walk_next   = ptr_inc(walk_reg);
                remain_next = remain_reg - 1'b1;
                if (rd_signed < min_reg)
                begin
                    min_next = rd_signed;
                end
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = S_MIN_OUT;
                end
            end

            S_MIN_OUT:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_value_next = unsigned'(min_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Read address: the head entry while idle, else the entry under the walk pointer, or the next one on a step.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = head_reg;
        end
        else if (step)
        begin
            rd_addr = ptr_inc(walk_reg);
        end
        else
        begin
            rd_addr = walk_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_occ_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/fqmq_checker.sv =====
// Port-level checker for the FIFO queue with minimum query, bound to the top level.
module fqmq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fqmq_pkg::TDATA_W-1:0]  m_tdata,
    input logic [fqmq_pkg::STATUS_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import fqmq_pkg::*;

    // A stalled output beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // A full report is a single zero beat at full occupancy.
    a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_FULL |-> m_tlast
            && m_tdata[VALUE_W-1:0] == '0
            && m_tdata[VALUE_W+OCC_W-1:VALUE_W] == OCC_W'(DEPTH))
        else $error("full beat malformed");

    // An empty report is a single zero beat at zero occupancy.
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_EMPTY |-> m_tlast
            && m_tdata[VALUE_W-1:0] == '0
            && m_tdata[VALUE_W+OCC_W-1:VALUE_W] == '0)
        else $error("empty beat malformed");

    // Only a list walk gives beats before the last one, and those are good data.
    a_mid_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == STAT_OK)
        else $error("non-final beat carries an error status");

    // Input is taken only when the output register can take a new beat.
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while output beat is blocked");

endmodule

bind fifo_queue_with_min_query fqmq_checker u_fqmq_checker (.*);

// ===== tb/sv/fifo_queue_with_min_query_tb.sv =====
// Self-checking testbench for the FIFO queue with minimum query, with random flow control.
module fifo_queue_with_min_query_tb;

    import fqmq_pkg::*;

    localparam int          QUEUE_DEPTH     = DEPTH;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          RANDOM_ITEMS    = 340;
    localparam int          DRAIN_CYCLES    = 40;
    localparam logic [2:0]  ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  ACT_SPARE_LAST  = 3'd7;
    localparam logic [31:0] MOST_NEGATIVE   = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE   = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONES        = 32'hffff_ffff;

    // One output beat as the block should present it.
    typedef struct {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [OCC_W-1:0]    occupancy;
    } beat_t;

    // Keeps a copy of the queue and the beats that are still owed by the block.
    class queue_scoreboard;
        logic signed [VALUE_W-1:0] slots[QUEUE_DEPTH];
        int unsigned               head_idx;
        int unsigned               tail_idx;
        int unsigned               count;
        beat_t                     expected_beats[$];
        int                        errors;

        function new();
            head_idx = 0;
            tail_idx = 0;
            count    = 0;
            errors   = 0;
        endfunction

        function void push_beat(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                                logic last);
            beat_t b;
            b.value     = value;
            b.status    = status;
            b.last      = last;
            b.occupancy = count[OCC_W-1:0];
            expected_beats.push_back(b);
        endfunction

        // Apply one accepted action to the queue copy and queue up its beats.
        function void note_action(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value);
            logic signed [VALUE_W-1:0] best;
            int unsigned               pos;
            case (act)
                ACT_CLEAR:
                begin
                    head_idx = 0;
                    tail_idx = 0;
                    count    = 0;
                    push_beat('0, STAT_OK, 1'b1);
                end
                ACT_INSERT:
                begin
                    if (count >= QUEUE_DEPTH)
                    begin
                        push_beat('0, STAT_FULL, 1'b1);
                    end
                    else
                    begin
                        slots[tail_idx] = value;
                        tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                        count++;
                        push_beat('0, STAT_OK, 1'b1);
                    end
                end
                ACT_REMOVE:
                begin
                    if (count == 0)
                    begin
                        push_beat('0, STAT_EMPTY, 1'b1);
                    end
                    else
                    begin
                        best = slots[head_idx];
                        head_idx = (head_idx + 1) % QUEUE_DEPTH;
                        count--;
                        push_beat(best, STAT_OK, 1'b1);
                    end
                end
                ACT_LIST:
                begin
                    if (count == 0)
                    begin
                        push_beat('0, STAT_EMPTY, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < count; i++)
                        begin
                            pos = (head_idx + i) % QUEUE_DEPTH;
                            push_beat(slots[pos], STAT_OK, (i + 1 == count));
                        end
                    end
                end
                ACT_MIN:
                begin
                    if (count == 0)
                    begin
                        push_beat('0, STAT_EMPTY, 1'b1);
                    end
                    else
                    begin
                        best = slots[head_idx];
                        for (int i = 1; i < count; i++)
                        begin
                            pos = (head_idx + i) % QUEUE_DEPTH;
                            if (slots[pos] < best)
                                best = slots[pos];
                        end
                        push_beat(best, STAT_OK, 1'b1);
                    end
                end
                default:
                begin
                    // Spare action codes leave the queue alone.
                    push_beat('0, STAT_OK, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_val,
                                    logic [VALUE_W-1:0] act_val);
            if (exp_val !== act_val)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                         exp_val, act_val);
            end
        endfunction

        // Compare one accepted output beat with the oldest one owed.
        function void check_beat(logic [TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser,
                                 logic tlast);
            beat_t b;
            if (expected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual data %h status %h last %b",
                         $time, tdata, tuser, tlast);
            end
            else
            begin
                b = expected_beats.pop_front();
                compare_field("value_out", b.value, tdata[VALUE_W-1:0]);
                compare_field("occupancy", VALUE_W'(b.occupancy),
                              VALUE_W'(tdata[VALUE_W+OCC_W-1:VALUE_W]));
                compare_field("status", VALUE_W'(b.status), VALUE_W'(tuser));
                compare_field("last", VALUE_W'(b.last), VALUE_W'(tlast));
            end
        endfunction
    endclass

    // Clock and known input levels from time zero.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata = '0;   // [31:0] value_in
    logic [ACTION_W-1:0] s_tuser = '0;   // [2:0] action
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;   // [31:0] value_out, [36:32] occupancy
    logic [STATUS_W-1:0] m_tuser;   // [1:0] status
    logic                m_tlast;

    logic            steady_flow = 1'b0;
    int              cycle_count = 0;
    queue_scoreboard sb;

    fifo_queue_with_min_query i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // The receiver stalls about 13 percent of the time outside the steady stretch.
    always @(posedge clk)
    begin
        m_tready <= steady_flow || ($urandom_range(99) >= 13);
    end

    // Every accepted output beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[fifo_queue_with_min_query] ERROR");
            $finish;
        end
    end

    // Present one beat, with an occasional gap before it, and wait for it to be taken.
    task automatic send_action(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value);
        if (!steady_flow && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_action(act, value);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
        begin
            case ($urandom_range(3))
                0: return MOST_NEGATIVE;
                1: return MOST_POSITIVE;
                2: return '0;
                default: return ALL_ONES;
            endcase
        end
        else if (r <= 3)
            return $urandom_range(20) - 10;
        return $urandom();
    endfunction

    // Pick an action; the mix drifts between filling, draining and balanced traffic.
    function automatic logic [ACTION_W-1:0] pick_action(int idx);
        int unsigned r;
        int unsigned insert_cut;
        int unsigned remove_cut;
        r = $urandom_range(99);
        case ((idx / 40) % 3)
            0:
            begin
                insert_cut = 62;
                remove_cut = 75;
            end
            1:
            begin
                insert_cut = 25;
                remove_cut = 65;
            end
            default:
            begin
                insert_cut = 40;
                remove_cut = 65;
            end
        endcase
        if (r < 2)
            return ACT_CLEAR;
        else if (r < 5)
            return ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        else if (r < insert_cut)
            return ACT_INSERT;
        else if (r < remove_cut)
            return ACT_REMOVE;
        else if (r < 82)
            return ACT_LIST;
        return ACT_MIN;
    endfunction

    // Reset, directed cases, random traffic and the final verdict.
    initial
    begin
        logic [ACTION_W-1:0] act;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Actions on an empty queue.
        send_action(ACT_REMOVE, '0);
        send_action(ACT_LIST, '0);
        send_action(ACT_MIN, '0);

        // Value extremes, then list, minimum and remove over them, then spare actions.
        send_action(ACT_INSERT, MOST_POSITIVE);
        send_action(ACT_INSERT, MOST_NEGATIVE);
        send_action(ACT_INSERT, '0);
        send_action(ACT_INSERT, ALL_ONES);
        send_action(ACT_LIST, '0);
        send_action(ACT_MIN, '0);
        send_action(ACT_REMOVE, '0);
        send_action(ACT_SPARE_FIRST, ALL_ONES);
        send_action(ACT_SPARE_LAST, '0);

        // Fill to the top with the tail wrapping, hit the full case, then list, minimum and clear.
        while (sb.count < QUEUE_DEPTH)
            send_action(ACT_INSERT, $urandom());
        send_action(ACT_INSERT, MOST_NEGATIVE);
        send_action(ACT_LIST, '0);
        send_action(ACT_MIN, '0);
        send_action(ACT_CLEAR, '0);

        // Random traffic with a stretch of steady flow in the middle.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady_flow = (i >= 150 && i < 230);
            act = pick_action(i);
            send_action(act, pick_value());
        end
        steady_flow = 1'b0;
        s_tvalid <= 1'b0;

        // Drain the owed beats, then give the block time to show any extra one.
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("[fifo_queue_with_min_query] OK");
        else
            $display("[fifo_queue_with_min_query] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fqmq_pkg.sv
hdl/fifo_queue_with_min_query.sv
hdl/fqmq_checker.sv
tb/sv/fifo_queue_with_min_query_tb.sv
